@@ hdl/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("check failed");

// antecedent implies consequent on the next edge
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ hdl/wcm_pkg.sv @@
package wcm_pkg;

  localparam int unsigned LineShift = 6;
  localparam int unsigned AddrW = 64;
  localparam int unsigned LineW = AddrW - LineShift;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_RETIRE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_OUT  = 2'd2,
    S_DONE = 2'd3
  } fsm_t;

  // one stored entry: line, flag, range and walks
  localparam int unsigned EntryW = LineW + 1 + 2 * AddrW + 6 * AddrW;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic             mem;
    logic [AddrW-1:0] dstart;
    logic [AddrW-1:0] dend;
    logic [AddrW-1:0] iwa;
    logic [AddrW-1:0] iwb;
    logic [AddrW-1:0] iwc;
    logic [AddrW-1:0] dwa;
    logic [AddrW-1:0] dwb;
    logic [AddrW-1:0] dwc;
  } entry_t;

  function automatic logic [1:0] walk_cnt(input logic [AddrW-1:0] sa, input logic [AddrW-1:0] fa,
                                          input logic [AddrW-1:0] sb, input logic [AddrW-1:0] fb,
                                          input logic [AddrW-1:0] sc, input logic [AddrW-1:0] fc);
    logic [1:0] n;
    n = 2'd0;
    if (sa != '0 && sa == fa) n = n + 2'd1;
    if (sb != '0 && sb == fb) n = n + 2'd1;
    if (sc != '0 && sc == fc) n = n + 2'd1;
    return n;
  endfunction

endpackage

@@ hdl/wcm_ram.sv @@
module wcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/window_conflict_matcher.sv @@
// window_conflict_matcher: window of in-flight instructions with conflict compare
//
// input channel in_*: one beat per item, mode selects insert, retire or query.
// output channel out_*: one beat per result; out_last marks the final beat of
// an item. insert and query give one beat per stored entry, newest first, or a
// single no-entry beat on an empty window; retire and rejected items give one.
// entries live in one synchronous ram; an insert or query walks the entries
// from newest to oldest, reading a slot in the scan state and giving its
// result beat in the out state, and moves on only once that beat is taken;
// retire skips the scan, and every beat waits while out_stall is held.
// the block takes one item at a time; in_stall is high until the final
// result beat of the current item is taken.
// an insert writes the ram after its scan, so it never races its own reads.
// reset clears the pointers and the fill count; ram contents are don't care
// since only written slots are ever read.
// while out_stall is high the result beat holds and the scan waits.
module window_conflict_matcher
  import wcm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [63:0]       in_code_addr,
  input  logic              in_has_data_addr,
  input  logic [63:0]       in_data_start,
  input  logic [63:0]       in_data_end,
  input  logic [63:0]       in_iwalk_a,
  input  logic [63:0]       in_iwalk_b,
  input  logic [63:0]       in_iwalk_c,
  input  logic [63:0]       in_dwalk_a,
  input  logic [63:0]       in_dwalk_b,
  input  logic [63:0]       in_dwalk_c,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_has_entry,
  output logic [4:0]        out_entry_age,
  output logic              out_code_line_match,
  output logic [1:0]        out_iwalk_matches,
  output logic              out_range_overlap,
  output logic              out_data_line_match,
  output logic [1:0]        out_dwalk_matches,
  output logic              out_last,
  output logic [5:0]        out_occupancy
);

  `include "assert_macros.svh"

  localparam int unsigned PtrW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(WINDOW_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW_DEPTH);

  fsm_t state_r, state_nxt;
  logic [PtrW-1:0] oldest_r, oldest_nxt;
  logic [PtrW-1:0] newest_r, newest_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic [CntW-1:0] k_r, k_nxt;
  logic [PtrW-1:0] rd_slot_r, rd_slot_nxt;
  entry_t          item_r;
  logic            ins_r;

  // output beat registers
  logic       ov_r, ov_nxt;
  logic [1:0] o_status_r;
  logic       o_has_r;
  logic [4:0] o_age_r;
  logic       o_cl_r, o_rng_r, o_dl_r, o_last_r;
  logic [1:0] o_iw_r, o_dw_r;
  logic [5:0] o_occ_r;

  entry_t     rd_entry;
  logic [EntryW-1:0] rd_bits;
  logic       ram_we;
  logic       in_acc, out_acc;

  function automatic logic [PtrW-1:0] slot_inc(input logic [PtrW-1:0] s);
    return (s == LastSlot) ? '0 : s + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] slot_dec(input logic [PtrW-1:0] s);
    return (s == '0) ? LastSlot : s - PtrW'(1);
  endfunction

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // entry ram, written after the scan of an insert
  // read address is taken from rd_slot_nxt so the slot data is ready in scan
  assign ram_we = (state_r == S_DONE) && ins_r;

  wcm_ram #(.Width(EntryW), .Depth(WINDOW_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(newest_r),
    .wdata(item_r),
    .raddr(rd_slot_nxt),
    .rdata(rd_bits)
  );
  assign rd_entry = entry_t'(rd_bits);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_mode == MODE_INSERT && fill_r != FullCnt && fill_r != '0) ||
              (in_mode == MODE_QUERY && fill_r != '0)) state_nxt = S_SCAN;
          else state_nxt = S_DONE;
        end
      end
      S_SCAN:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) state_nxt = (k_r == fill_r) ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        if (!ov_r || out_acc) state_nxt = (ov_r && !out_acc) ? S_DONE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control datapath
  always_comb begin
    oldest_nxt  = oldest_r;
    newest_nxt  = newest_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    rd_slot_nxt = rd_slot_r;
    ov_nxt      = ov_r && out_stall;
    case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        rd_slot_nxt = slot_dec(newest_r);
      end
      S_SCAN: begin
        ov_nxt = 1'b1;
        k_nxt = k_r + CntW'(1);
        rd_slot_nxt = slot_dec(rd_slot_r);
      end
      S_DONE: begin
        if (ram_we) begin
          newest_nxt = slot_inc(newest_r);
          fill_nxt = fill_r + CntW'(1);
        end
      end
      default: ;
    endcase
    if (in_acc) begin
      if (in_mode == MODE_RETIRE && fill_r != '0) begin
        oldest_nxt = slot_inc(oldest_r);
        fill_nxt = fill_r - CntW'(1);
      end
      if (!((in_mode == MODE_INSERT && fill_r != FullCnt && fill_r != '0) ||
            (in_mode == MODE_QUERY && fill_r != '0))) ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oldest_r <= '0;
      newest_r <= '0;
      fill_r   <= '0;
      k_r      <= '0;
      rd_slot_r <= '0;
      ov_r     <= 1'b0;
      ins_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      fill_r   <= fill_nxt;
      k_r      <= k_nxt;
      rd_slot_r <= rd_slot_nxt;
      ov_r     <= ov_nxt;
      if (in_acc) ins_r <= (in_mode == MODE_INSERT) && (fill_r != FullCnt);
      else if (state_r == S_DONE) ins_r <= 1'b0;
    end
  end

  // capture the incoming item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.line   <= in_code_addr[AddrW-1:LineShift];
      item_r.mem    <= in_has_data_addr;
      item_r.dstart <= in_data_start;
      item_r.dend   <= in_data_end;
      item_r.iwa    <= in_iwalk_a;
      item_r.iwb    <= in_iwalk_b;
      item_r.iwc    <= in_iwalk_c;
      item_r.dwa    <= in_dwalk_a;
      item_r.dwb    <= in_dwalk_b;
      item_r.dwc    <= in_dwalk_c;
    end
  end

  // result beat payload
  logic both;
  logic [CntW-1:0] occ_after;
  assign both = item_r.mem && rd_entry.mem;
  assign occ_after = (in_mode == MODE_INSERT) ? fill_r + CntW'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (in_acc && ov_nxt) begin
      if (in_mode == MODE_RETIRE && fill_r == '0) o_status_r <= ST_EMPTY;
      else if (in_mode == MODE_INSERT && fill_r == FullCnt) o_status_r <= ST_FULL;
      else o_status_r <= ST_OK;
      if (in_mode == MODE_INSERT && fill_r == '0) o_occ_r <= 6'(occ_after);
      else o_occ_r <= 6'(fill_nxt);
      o_has_r  <= 1'b0;
      o_age_r  <= '0;
      o_cl_r   <= 1'b0;
      o_iw_r   <= '0;
      o_rng_r  <= 1'b0;
      o_dl_r   <= 1'b0;
      o_dw_r   <= '0;
      o_last_r <= 1'b1;
    end else if (state_r == S_SCAN) begin
      o_status_r <= ST_OK;
      o_has_r  <= 1'b1;
      o_age_r  <= 5'(k_r);
      o_cl_r   <= (rd_entry.line == item_r.line);
      o_iw_r   <= walk_cnt(rd_entry.iwa, item_r.iwa, rd_entry.iwb, item_r.iwb,
                           rd_entry.iwc, item_r.iwc);
      o_rng_r  <= both && (item_r.dend >= rd_entry.dstart) && (item_r.dstart <= rd_entry.dend);
      o_dl_r   <= both && (item_r.dstart[AddrW-1:LineShift] ==
                           rd_entry.dstart[AddrW-1:LineShift]);
      o_dw_r   <= both ? walk_cnt(rd_entry.dwa, item_r.dwa, rd_entry.dwb, item_r.dwb,
                                  rd_entry.dwc, item_r.dwc) : 2'd0;
      o_last_r <= (k_r + CntW'(1) == fill_r);
      o_occ_r  <= 6'(fill_r + (ins_r ? CntW'(1) : CntW'(0)));
    end
  end

  assign out_valid           = ov_r;
  assign out_status          = o_status_r;
  assign out_has_entry       = o_has_r;
  assign out_entry_age       = o_age_r;
  assign out_code_line_match = o_cl_r;
  assign out_iwalk_matches   = o_iw_r;
  assign out_range_overlap   = o_rng_r;
  assign out_data_line_match = o_dl_r;
  assign out_dwalk_matches   = o_dw_r;
  assign out_last            = o_last_r;
  assign out_occupancy       = o_occ_r;

  // checks
  `CHK_ALWAYS(a_fill_range, clk, rst_n, fill_r <= FullCnt)
  `CHK_ALWAYS(a_ptr_gap, clk, rst_n,
              newest_r == PtrW'(32'(oldest_r) + 32'(fill_r)) ||
              newest_r == PtrW'(32'(oldest_r) + 32'(fill_r) - WINDOW_DEPTH))
  `CHK_NEXT(a_write_once, clk, rst_n, ram_we, !ram_we)
  `CHK_ALWAYS(a_busy_no_take, clk, rst_n, !(state_r != S_IDLE && in_acc))

endmodule
